// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the triangle normal block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clock edge outside reset.
`define TNBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define TNBC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TNBC_ASSERT(lbl, prop, msg)
`define TNBC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/tnbc_pkg.sv =====
// Package with types, widths and register codes of the triangle normal block.
`default_nettype none
package tnbc_pkg;

  localparam int CW     = 32;  // coordinate width, Q16.16
  localparam int EW     = 33;  // edge and offset width
  localparam int PW     = 66;  // edge product width
  localparam int XW     = 67;  // cross component width
  localparam int MAGW   = 65;  // cross magnitude width
  localparam int BLW    = 7;   // bit length of a cross magnitude, 0..65
  localparam int MW     = 31;  // normalised magnitude width
  localparam int SQW    = 62;  // square of a normalised magnitude
  localparam int SUMW   = 64;  // sum of squares
  localparam int RTW    = 32;  // square root width
  localparam int REMW   = 36;  // square root remainder width
  localparam int NUMW   = 47;  // dividend width
  localparam int DENW   = 33;  // divisor width
  localparam int QW     = 15;  // quotient magnitude width
  localparam int NW     = 16;  // Q1.14 normal component width
  localparam int DPW    = 49;  // normal times offset
  localparam int DOTW   = 51;  // dot product sum

  localparam int SQ_STAGES  = 8;
  localparam int SQ_STEPS   = RTW / SQ_STAGES;
  localparam int DIV_STAGES = 5;
  localparam int DIV_STEPS  = QW / DIV_STAGES;

  // Pipeline stage numbers.
  localparam int ST_SUM  = 7;
  localparam int ST_DIV0 = ST_SUM + SQ_STAGES + 1;
  localparam int ST_DOT  = ST_DIV0 + DIV_STAGES + 1;
  localparam int NS      = ST_DOT + 1;

  typedef enum logic [1:0] {
    REG_CAMERA_X = 2'd0,
    REG_CAMERA_Y = 2'd1,
    REG_CAMERA_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
  } vert_t;

  typedef struct packed {
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [NW-1:0] normal_z;
    logic                 facing;
    logic                 degenerate;
  } res_t;

  typedef struct packed {
    logic signed [EW-1:0] x;
    logic signed [EW-1:0] y;
    logic signed [EW-1:0] z;
  } vec33_t;

endpackage
`default_nettype wire

// ===== rtl/core/tnbc_div.sv =====
// Pipelined restoring divider giving one rounded normal magnitude per cycle unless its stages are held.
`default_nettype none
module tnbc_div (
  input  wire logic                              clk,
  input  wire logic [tnbc_pkg::DIV_STAGES:0]     ld,
  input  wire logic [tnbc_pkg::MW-1:0]           m,
  input  wire logic [tnbc_pkg::RTW-1:0]          len,
  output      logic [tnbc_pkg::QW-1:0]           quo
);

  logic [tnbc_pkg::NUMW-1:0] rem_q [0:tnbc_pkg::DIV_STAGES];
  logic [tnbc_pkg::DENW-1:0] den_q [0:tnbc_pkg::DIV_STAGES];
  logic [tnbc_pkg::QW-1:0]   quo_q [0:tnbc_pkg::DIV_STAGES];

  // Dividend m * 32768 + len over divisor 2 * len rounds half away from zero.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rem_q[0] <= tnbc_pkg::NUMW'({m, 15'd0}) + tnbc_pkg::NUMW'(len);
      den_q[0] <= {len, 1'b0};
      quo_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= tnbc_pkg::DIV_STAGES; j++) begin : g_stage
    logic [tnbc_pkg::NUMW-1:0] rem_next;
    logic [tnbc_pkg::QW-1:0]   quo_next;
    logic [tnbc_pkg::NUMW-1:0] dsh;

    always_comb begin
      rem_next = rem_q[j-1];
      quo_next = quo_q[j-1];
      dsh      = '0;
      for (int s = 0; s < tnbc_pkg::DIV_STEPS; s++) begin
        dsh = tnbc_pkg::NUMW'(den_q[j-1]) << (tnbc_pkg::QW - 1 - (j-1)*tnbc_pkg::DIV_STEPS - s);
        if (rem_next >= dsh) begin
          rem_next = rem_next - dsh;
          quo_next = {quo_next[tnbc_pkg::QW-2:0], 1'b1};
        end else begin
          quo_next = {quo_next[tnbc_pkg::QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        rem_q[j] <= rem_next;
        den_q[j] <= den_q[j-1];
        quo_q[j] <= quo_next;
      end
    end
  end

  assign quo = quo_q[tnbc_pkg::DIV_STAGES];

endmodule
`default_nettype wire

// ===== rtl/core/triangle_normal_backface_cull.sv =====
// Top level of the triangle face normal and back-face test pipeline.
//
//  channel  | handshake                | word
//  ---------+--------------------------+-------------------------------------
//  vertices | vert_valid / vert_ready  | verts : three Q16.16 vertices
//  result   | res_valid / res_ready    | res   : Q1.14 normal, facing, degenerate
//  config   | cfg_we                   | cfg_index, cfg_data : camera position
//
// One word is taken every cycle unless a stall on the result side reaches the
// entry. A result goes valid once its word has passed through every stage.
// Most of the pipeline depth lies in the square root, eight stages of four result
// bits each, and in the three dividers, one prep stage and five stages of
// three quotient bits each.
// Reset is synchronous and empties every stage; the camera returns to the
// origin. A stall on the result side holds each full stage, and empty stages
// ahead of the stall still fill, so no word is lost or repeated.
`default_nettype none
`include "assert_macros.svh"
module triangle_normal_backface_cull (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                vert_valid,
  output      logic                vert_ready,
  input  wire tnbc_pkg::vert_t     verts,
  output      logic                res_valid,
  input  wire logic                res_ready,
  output      tnbc_pkg::res_t      res,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [tnbc_pkg::CW-1:0] cfg_data
);

  localparam int NS = tnbc_pkg::NS;

  // Camera registers.
  logic signed [tnbc_pkg::CW-1:0] cam_x, cam_y, cam_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
    end else if (cfg_we) begin
      case (tnbc_pkg::reg_idx_t'(cfg_index))
        tnbc_pkg::REG_CAMERA_X: cam_x <= cfg_data;
        tnbc_pkg::REG_CAMERA_Y: cam_y <= cfg_data;
        tnbc_pkg::REG_CAMERA_Z: cam_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits and the ready chain. A stage loads whenever it is empty or
  // its content moves on in the same cycle.
  logic [NS:1]   vld;
  logic [NS:1]   vld_prev;
  logic [NS+1:1] rdy;

  assign vld_prev = {vld[NS-1:1], vert_valid};
  assign rdy[NS+1] = res_ready;
  for (genvar k = 1; k <= NS; k++) begin : g_rdy
    assign rdy[k] = ~vld[k] | rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) vld[k] <= vld_prev[k];
      end
    end
  end

  assign vert_ready = rdy[1];
  assign res_valid  = vld[NS];

  // Stage 1: edge vectors from vertex 0 and the offset from the camera.
  // The camera offset then rides along until the dot product.
  tnbc_pkg::vec33_t e1, e2;
  tnbc_pkg::vec33_t off_pipe [1:tnbc_pkg::ST_DOT];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      e1.x <= {verts.v1_x[31], verts.v1_x} - {verts.v0_x[31], verts.v0_x};
      e1.y <= {verts.v1_y[31], verts.v1_y} - {verts.v0_y[31], verts.v0_y};
      e1.z <= {verts.v1_z[31], verts.v1_z} - {verts.v0_z[31], verts.v0_z};
      e2.x <= {verts.v2_x[31], verts.v2_x} - {verts.v0_x[31], verts.v0_x};
      e2.y <= {verts.v2_y[31], verts.v2_y} - {verts.v0_y[31], verts.v0_y};
      e2.z <= {verts.v2_z[31], verts.v2_z} - {verts.v0_z[31], verts.v0_z};
      off_pipe[1].x <= {verts.v0_x[31], verts.v0_x} - {cam_x[31], cam_x};
      off_pipe[1].y <= {verts.v0_y[31], verts.v0_y} - {cam_y[31], cam_y};
      off_pipe[1].z <= {verts.v0_z[31], verts.v0_z} - {cam_z[31], cam_z};
    end
    for (int k = 2; k <= tnbc_pkg::ST_DOT; k++) begin
      if (rdy[k]) off_pipe[k] <= off_pipe[k-1];
    end
  end

  // Stage 2: the six exact edge products of the cross product.
  logic signed [tnbc_pkg::PW-1:0] p [0:5];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      p[0] <= e1.y * e2.z;
      p[1] <= e1.z * e2.y;
      p[2] <= e1.z * e2.x;
      p[3] <= e1.x * e2.z;
      p[4] <= e1.x * e2.y;
      p[5] <= e1.y * e2.x;
    end
  end

  // Stage 3: cross components, split into sign and magnitude.
  logic [tnbc_pkg::XW-1:0]   cr   [0:2];
  logic [tnbc_pkg::XW-1:0]   crab [0:2];
  logic [2:0][tnbc_pkg::MAGW-1:0] mag3, mag4;
  logic [2:0] neg_pipe [3:tnbc_pkg::ST_DOT];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i]   = {p[2*i][tnbc_pkg::PW-1], p[2*i]} - {p[2*i+1][tnbc_pkg::PW-1], p[2*i+1]};
      crab[i] = cr[i][tnbc_pkg::XW-1] ? (~cr[i] + 1'b1) : cr[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        mag3[i]        <= crab[i][tnbc_pkg::MAGW-1:0];
        neg_pipe[3][i] <= cr[i][tnbc_pkg::XW-1];
      end
    end
    for (int k = 4; k <= tnbc_pkg::ST_DOT; k++) begin
      if (rdy[k]) neg_pipe[k] <= neg_pipe[k-1];
    end
  end

  // Stage 4: bit length of the largest magnitude. Zero marks a degenerate face.
  logic [tnbc_pkg::MAGW-1:0] mag_or;
  logic [tnbc_pkg::BLW-1:0]  blen, blen_q;

  always_comb begin
    mag_or = mag3[0] | mag3[1] | mag3[2];
    blen   = '0;
    for (int i = 0; i < tnbc_pkg::MAGW; i++) begin
      if (mag_or[i]) blen = tnbc_pkg::BLW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      blen_q <= blen;
      mag4   <= mag3;
    end
  end

  // Stage 5: block scaling so the largest magnitude sits in [2^30, 2^31).
  // One right shift of magnitude * 2^31 by the bit length covers both the
  // left and the truncating right shift.
  logic [tnbc_pkg::MW-1:0] m_pipe [5:tnbc_pkg::ST_DIV0][0:2];
  logic                    deg_pipe [5:NS-1];
  logic [tnbc_pkg::MAGW+tnbc_pkg::MW-1:0] wide [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {mag4[i], {tnbc_pkg::MW{1'b0}}} >> blen_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) m_pipe[5][i] <= wide[i][tnbc_pkg::MW-1:0];
      deg_pipe[5] <= (blen_q == '0);
    end
    for (int k = 6; k <= tnbc_pkg::ST_DIV0; k++) begin
      if (rdy[k]) m_pipe[k] <= m_pipe[k-1];
    end
    for (int k = 6; k <= NS-1; k++) begin
      if (rdy[k]) deg_pipe[k] <= deg_pipe[k-1];
    end
  end

  // Stage 6: squares. Stage 7: their sum, the square root radicand.
  logic [tnbc_pkg::SQW-1:0]  sq [0:2];
  logic [tnbc_pkg::SUMW-1:0] rad_q  [0:tnbc_pkg::SQ_STAGES];
  logic [tnbc_pkg::REMW-1:0] rem_q  [0:tnbc_pkg::SQ_STAGES];
  logic [tnbc_pkg::RTW-1:0]  root_q [0:tnbc_pkg::SQ_STAGES];

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int i = 0; i < 3; i++) sq[i] <= m_pipe[5][i] * m_pipe[5][i];
    end
    if (rdy[tnbc_pkg::ST_SUM]) begin
      rad_q[0]  <= tnbc_pkg::SUMW'(sq[0]) + tnbc_pkg::SUMW'(sq[1])
                 + tnbc_pkg::SUMW'(sq[2]);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  // Square root: restoring, two radicand bits in and one root bit out per step.
  for (genvar j = 1; j <= tnbc_pkg::SQ_STAGES; j++) begin : g_sqrt
    logic [tnbc_pkg::SUMW-1:0] rad_next;
    logic [tnbc_pkg::REMW-1:0] rem_next, rem_t, trial;
    logic [tnbc_pkg::RTW-1:0]  root_next;

    always_comb begin
      rad_next  = rad_q[j-1];
      rem_next  = rem_q[j-1];
      root_next = root_q[j-1];
      rem_t     = '0;
      trial     = '0;
      for (int s = 0; s < tnbc_pkg::SQ_STEPS; s++) begin
        rem_t    = {rem_next[tnbc_pkg::REMW-3:0], rad_next[tnbc_pkg::SUMW-1 -: 2]};
        rad_next = {rad_next[tnbc_pkg::SUMW-3:0], 2'b00};
        trial    = tnbc_pkg::REMW'({root_next, 2'b01});
        if (rem_t >= trial) begin
          rem_next  = rem_t - trial;
          root_next = {root_next[tnbc_pkg::RTW-2:0], 1'b1};
        end else begin
          rem_next  = rem_t;
          root_next = {root_next[tnbc_pkg::RTW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[tnbc_pkg::ST_SUM + j]) begin
        rad_q[j]  <= rad_next;
        rem_q[j]  <= rem_next;
        root_q[j] <= root_next;
      end
    end
  end

  // Dividers, one lane per component.
  logic [tnbc_pkg::DIV_STAGES:0] div_ld;
  logic [tnbc_pkg::QW-1:0]       quo [0:2];

  assign div_ld = rdy[tnbc_pkg::ST_DOT-1:tnbc_pkg::ST_DIV0];

  for (genvar i = 0; i < 3; i++) begin : g_div
    tnbc_div u_div (
      .clk (clk),
      .ld  (div_ld),
      .m   (m_pipe[tnbc_pkg::ST_DIV0-1][i]),
      .len (root_q[tnbc_pkg::SQ_STAGES]),
      .quo (quo[i])
    );
  end

  // Dot product stage: signed normal and the products with the camera offset.
  logic signed [tnbc_pkg::NW-1:0]  nrm   [0:2];
  logic signed [tnbc_pkg::NW-1:0]  nrm_q [0:2];
  logic signed [tnbc_pkg::DPW-1:0] dp    [0:2];
  logic signed [tnbc_pkg::EW-1:0]  offc  [0:2];

  always_comb begin
    offc[0] = off_pipe[tnbc_pkg::ST_DOT-1].x;
    offc[1] = off_pipe[tnbc_pkg::ST_DOT-1].y;
    offc[2] = off_pipe[tnbc_pkg::ST_DOT-1].z;
    for (int i = 0; i < 3; i++) begin
      nrm[i] = neg_pipe[tnbc_pkg::ST_DOT-1][i] ? -$signed({1'b0, quo[i]})
                                               :  $signed({1'b0, quo[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[tnbc_pkg::ST_DOT]) begin
      for (int i = 0; i < 3; i++) begin
        nrm_q[i] <= nrm[i];
        dp[i]    <= nrm[i] * offc[i];
      end
    end
  end

  // Output stage: sum of products and the degenerate override.
  logic signed [tnbc_pkg::DOTW-1:0] dsum;
  logic                             deg_o;

  assign deg_o = deg_pipe[NS-1];

  always_comb begin
    dsum = tnbc_pkg::DOTW'(dp[0]) + tnbc_pkg::DOTW'(dp[1]) + tnbc_pkg::DOTW'(dp[2]);
  end

  always_ff @(posedge clk) begin
    if (rdy[NS]) begin
      res.normal_x   <= deg_o ? '0 : nrm_q[0];
      res.normal_y   <= deg_o ? '0 : nrm_q[1];
      res.normal_z   <= deg_o ? '0 : nrm_q[2];
      res.facing     <= ~deg_o & dsum[tnbc_pkg::DOTW-1];
      res.degenerate <= deg_o;
    end
  end

  // A degenerate face carries a zero normal and never faces the camera.
  `TNBC_ASSERT(a_deg_zero, res_valid && res.degenerate |-> res.normal_x == 0 && res.normal_y == 0 && res.normal_z == 0 && !res.facing, "degenerate word with nonzero normal")
  // A proper face has a nonzero normal, and the x component stays in the unit range.
  `TNBC_ASSERT(a_norm_nz, res_valid && !res.degenerate |-> res.normal_x != 0 || res.normal_y != 0 || res.normal_z != 0, "zero normal on a proper face")
  `TNBC_ASSERT(a_norm_rng, res_valid |-> res.normal_x >= -16384 && res.normal_x <= 16384, "normal x out of range")
  // An accepted word always lands in the first stage.
  `TNBC_ASSERT(a_enter, vert_valid && vert_ready |=> vld[1], "accepted word lost at entry")
  `TNBC_ASSERT_RST(a_rst_empty, rst |=> vld == '0, "pipeline not empty after reset")

endmodule
`default_nettype wire

// ===== tb/normal_checker.sv =====
// Checker that predicts and compares the face normal results of the culling block.
`timescale 1ns / 1ps
`default_nettype none
module normal_checker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vert_valid,
  input  wire logic             vert_ready,
  input  wire tnbc_pkg::vert_t  verts,
  input  wire logic             res_valid,
  input  wire logic             res_ready,
  input  wire tnbc_pkg::res_t   res,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [31:0]      cfg_data,
  output int                    pending,
  output int                    failures
);

  logic signed [31:0] camera [3];
  tnbc_pkg::res_t faces_due [$];

  // Integer square root, floor, by the bit-pair method.
  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] acc;
    logic [63:0] bitv;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= acc + bitv) begin
        s   = s - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  function automatic tnbc_pkg::res_t face_of(tnbc_pkg::vert_t w);
    logic signed [31:0] p0 [3];
    logic signed [31:0] p1 [3];
    logic signed [31:0] p2 [3];
    logic signed [32:0] e1 [3];
    logic signed [32:0] e2 [3];
    logic signed [32:0] off [3];
    logic signed [66:0] crs [3];
    logic [66:0]        mag [3];
    logic [63:0]        m [3];
    logic [63:0]        sum, len, q;
    logic signed [63:0] n [3];
    logic signed [63:0] dot;
    int                 bl;
    tnbc_pkg::res_t     r;
    p0 = '{w.v0_x, w.v0_y, w.v0_z};
    p1 = '{w.v1_x, w.v1_y, w.v1_z};
    p2 = '{w.v2_x, w.v2_y, w.v2_z};
    for (int i = 0; i < 3; i++) begin
      e1[i]  = $signed({p1[i][31], p1[i]}) - $signed({p0[i][31], p0[i]});
      e2[i]  = $signed({p2[i][31], p2[i]}) - $signed({p0[i][31], p0[i]});
      off[i] = $signed({p0[i][31], p0[i]}) - $signed({camera[i][31], camera[i]});
    end
    crs[0] = e1[1] * e2[2] - e1[2] * e2[1];
    crs[1] = e1[2] * e2[0] - e1[0] * e2[2];
    crs[2] = e1[0] * e2[1] - e1[1] * e2[0];
    bl = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = crs[i] < 0 ? -crs[i] : crs[i];
      for (int k = 0; k < 65; k++) if (mag[i][k] && k + 1 > bl) bl = k + 1;
    end
    r = '0;
    if (bl == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    // Block scaling puts the largest magnitude in [2^30, 2^31).
    for (int i = 0; i < 3; i++)
      m[i] = bl > 31 ? 64'(mag[i] >> (bl - 31)) : 64'(mag[i] << (31 - bl));
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = root_floor(sum);
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      q    = (m[i] * 64'd32768 + len) / (2 * len);
      n[i] = crs[i] < 0 ? -$signed(q) : $signed(q);
      dot  = dot + n[i] * off[i];
    end
    r.normal_x = n[0][15:0];
    r.normal_y = n[1][15:0];
    r.normal_z = n[2][15:0];
    r.facing   = dot < 0;
    return r;
  endfunction

  assign pending = faces_due.size();

  always @(posedge clk) begin
    tnbc_pkg::res_t want;
    if (rst) begin
      faces_due.delete();
      camera   <= '{default: '0};
      failures <= 0;
    end else begin
      if (vert_valid && vert_ready) faces_due.push_back(face_of(verts));
      if (cfg_we) begin
        case (cfg_index)
          tnbc_pkg::REG_CAMERA_X: camera[0] <= cfg_data;
          tnbc_pkg::REG_CAMERA_Y: camera[1] <= cfg_data;
          tnbc_pkg::REG_CAMERA_Z: camera[2] <= cfg_data;
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (faces_due.size() == 0) begin
          failures <= failures + 1;
          if (failures < 10) $display("unexpected result word %p", res);
        end else begin
          want = faces_due.pop_front();
          if (res.normal_x !== want.normal_x || res.normal_y !== want.normal_y ||
              res.normal_z !== want.normal_z || res.facing !== want.facing ||
              res.degenerate !== want.degenerate) begin
            failures <= failures + 1;
            if (failures < 10) $display("result mismatch: expected %p, got %p", want, res);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the testbench: stimulus, camera settings, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  // An index with no register behind it; writes there must change nothing.
  localparam logic [1:0] IDX_SPARE = 2'd3;
  localparam int         IDLE_LIMIT = 5000;
  localparam int         DRAIN_CYCLES = 40;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            vert_valid = 1'b0;
  logic            vert_ready;
  tnbc_pkg::vert_t verts = '0;
  logic            res_valid;
  logic            res_ready = 1'b0;
  tnbc_pkg::res_t  res;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = tnbc_pkg::REG_CAMERA_X;
  logic [31:0]     cfg_data = '0;
  int              pending, failures;
  int              idle_cycles = 0;
  int              burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_normal_backface_cull dut (
    .clk, .rst, .vert_valid, .vert_ready, .verts,
    .res_valid, .res_ready, .res, .cfg_we, .cfg_index, .cfg_data
  );

  normal_checker u_scoreboard (
    .clk, .rst, .vert_valid, .vert_ready, .verts,
    .res_valid, .res_ready, .res, .cfg_we, .cfg_index, .cfg_data,
    .pending, .failures
  );

  // The watchdog counts cycles in which no word crosses either channel.
  always @(posedge clk) begin
    if (rst || (vert_valid && vert_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // The receiver switches at random between keeping up, stalling at random
  // and stalling heavily.
  always @(negedge clk) begin
    int mode;
    if ($urandom_range(0, 63) == 0 || mode > 2) mode = $urandom_range(0, 2);
    case (mode)
      0: res_ready <= 1'b1;
      1: res_ready <= $urandom_range(0, 1);
      default: res_ready <= $urandom_range(0, 3) == 0;
    endcase
  end

  // Sends one word, in bursts separated by random gaps; a burst may run
  // without any gap at all.
  task automatic send_triangle(tnbc_pkg::vert_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        vert_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    verts      <= w;
    vert_valid <= 1'b1;
    do @(posedge clk); while (!vert_ready);
  endtask

  // Waits until every expected result is in, then lets the pipe drain.
  task automatic wait_drained();
    @(negedge clk);
    vert_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic place_camera(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    write_reg(tnbc_pkg::REG_CAMERA_X, x);
    write_reg(tnbc_pkg::REG_CAMERA_Y, y);
    write_reg(tnbc_pkg::REG_CAMERA_Z, z);
    write_reg(IDX_SPARE, $urandom);
  endtask

  function automatic tnbc_pkg::vert_t tri_of(int a0, int a1, int a2, int b0, int b1, int b2,
                                             int c0, int c1, int c2);
    tnbc_pkg::vert_t w;
    w = {a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return w;
  endfunction

  // Random triangles: mostly small well-formed ones around a random point,
  // with full-range noise and degenerate shapes mixed in.
  function automatic tnbc_pkg::vert_t random_triangle();
    tnbc_pkg::vert_t w;
    int              base [3];
    int              spread;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: ;
      2: begin
        w.v1_x = w.v0_x; w.v1_y = w.v0_y; w.v1_z = w.v0_z;
      end
      3: begin
        w.v2_x = w.v1_x; w.v2_y = w.v1_y; w.v2_z = w.v1_z;
      end
      default: begin
        spread = 1 << $urandom_range(0, 24);
        foreach (base[i]) base[i] = $urandom;
        w = tri_of(base[0], base[1], base[2],
                   base[0] + $urandom_range(0, spread), base[1] + $urandom_range(0, spread),
                   base[2] - $urandom_range(0, spread),
                   base[0] - $urandom_range(0, spread), base[1] + $urandom_range(0, spread),
                   base[2] + $urandom_range(0, spread));
      end
    endcase
    return w;
  endfunction

  localparam int MX = 32'h7fffffff;
  localparam int MN = 32'h80000000;
  localparam int ONE = 32'h00010000;

  initial begin
    tnbc_pkg::vert_t directed [$];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words with the camera at the origin.
    place_camera(0, 0, 0);
    directed = '{
      tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0),                     // all vertices equal
      tri_of(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE),   // collinear
      tri_of(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE),           // z plane, counter-clockwise
      tri_of(0, 0, ONE, 0, ONE, ONE, ONE, 0, ONE),           // opposite winding
      tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0),                 // camera in the plane: dot zero
      tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0),                     // smallest cross product
      tri_of(MN, MN, MN, MX, MN, MN, MN, MX, MN),            // extreme coordinates
      tri_of(MX, MX, MX, MN, MX, MX, MX, MN, MX),
      tri_of(MN, MX, MN, MX, MN, MX, MN, MN, MX),
      tri_of(MN, MN, MN, MX, MX, MX, MN, MN, MN),            // degenerate at the extremes
      tri_of(MX, MN, 0, MN, MX, 0, MX, MX, MN),
      tri_of(-1, -1, -1, MX, 0, 0, 0, MX, 0),
      tri_of(0, 0, 0, ONE, 0, 0, ONE, 1, 1),                 // nearly flat
      tri_of(0, 0, 0, 3, 0, 0, 0, 0, 5),
      tri_of(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE),
      tri_of(MX, MX, MX, MX, MX, MX, MX, MX, MX)
    };
    foreach (directed[i]) send_triangle(directed[i]);
    wait_drained();

    // Random words under a series of camera positions, extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: place_camera(0, 0, 0);
        1: place_camera(MX, MX, MX);
        2: place_camera(MN, MN, MN);
        3: place_camera(MX, MN, 0);
        default: place_camera($urandom, $urandom, $urandom);
      endcase
      repeat (225) send_triangle(random_triangle());
      wait_drained();
    end

    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
